// ===== rtl/gnsm_pkg.sv =====
package gnsm_pkg;

   localparam int MAX_SEATS_DEFAULT  = 64;
   localparam int COORD_BITS_DEFAULT = 12;

   localparam int FIELD_COORD_W = 12;
   localparam int INDEX_W       = 6;
   localparam int IDENT_W       = 16;
   localparam int COUNT_W       = 7;
   localparam int DIST_W        = 27;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   // request tdata layout
   localparam int SEAT_INDEX_LSB = 0;
   localparam int SEAT_X_LSB     = SEAT_INDEX_LSB + INDEX_W;
   localparam int SEAT_Y_LSB     = SEAT_X_LSB + FIELD_COORD_W;
   localparam int SEAT_W_LSB     = SEAT_Y_LSB + FIELD_COORD_W;
   localparam int SEAT_H_LSB     = SEAT_W_LSB + FIELD_COORD_W;
   localparam int SEAT_IDENT_LSB = SEAT_H_LSB + FIELD_COORD_W;
   localparam int FACE_X_LSB     = SEAT_IDENT_LSB + IDENT_W;
   localparam int FACE_Y_LSB     = FACE_X_LSB + FIELD_COORD_W;
   localparam int FACE_W_LSB     = FACE_Y_LSB + FIELD_COORD_W;
   localparam int FACE_H_LSB     = FACE_W_LSB + FIELD_COORD_W;
   localparam int REQ_FIELDS_W   = FACE_H_LSB + FIELD_COORD_W;
   localparam int REQ_TDATA_W    = ((REQ_FIELDS_W + 7) / 8) * 8;

   localparam int RSP_FIELDS_W   = IDENT_W + DIST_W;
   localparam int RSP_TDATA_W    = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } gnsm_state_type;

   typedef struct packed {
      logic busy;
      logic found;
   } gnsm_scan_status_type;

endpackage

// ===== rtl/gnsm_seat_table.sv =====
module gnsm_seat_table #(
   parameter  int DEPTH   = 64,
   parameter  int ENTRY_W = 64,
   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [ENTRY_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output logic               rd_valid,
   output logic [ENTRY_W-1:0] rd_data
);

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic               rd_valid_ff;
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_en;
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_data  = rd_data_ff;

endmodule

// ===== rtl/gnsm_dist_unit.sv =====
module gnsm_dist_unit #(
   parameter  int COORD_BITS = 12,
   localparam int ENTRY_W    = 4 * COORD_BITS + gnsm_pkg::IDENT_W,
   localparam int CEN_W      = COORD_BITS + 2,
   localparam int SQ_W       = 2 * CEN_W,
   localparam int DSUM_W     = SQ_W + 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             clear,
   input  logic                             in_valid,
   input  logic [ENTRY_W-1:0]               in_entry,
   input  logic [CEN_W-1:0]                 face_cx,
   input  logic [CEN_W-1:0]                 face_cy,
   output gnsm_pkg::gnsm_scan_status_type   status,
   output logic [DSUM_W-1:0]                best_dist,
   output logic [gnsm_pkg::IDENT_W-1:0]     best_ident
);

   import gnsm_pkg::*;

   logic [COORD_BITS-1:0] seat_x;
   logic [COORD_BITS-1:0] seat_y;
   logic [COORD_BITS-1:0] seat_w;
   logic [COORD_BITS-1:0] seat_h;
   logic [IDENT_W-1:0]    seat_id;
   logic [CEN_W-1:0]      seat_cx;
   logic [CEN_W-1:0]      seat_cy;

   logic               va_ff, vb_ff, vc_ff;
   logic [CEN_W-1:0]   dx_ff, dx_in;
   logic [CEN_W-1:0]   dy_ff, dy_in;
   logic [CEN_W-1:0]   w3_ff, w3_in;
   logic [IDENT_W-1:0] id_a_ff, id_b_ff, id_c_ff;
   logic [SQ_W-1:0]    dxsq_ff, dxsq_in;
   logic [SQ_W-1:0]    dysq_ff, dysq_in;
   logic [SQ_W-1:0]    gate_b_ff, gate_b_in;
   logic [SQ_W-1:0]    gate_c_ff;
   logic [DSUM_W-1:0]  dsum_ff, dsum_in;

   logic               found_ff, found_in;
   logic [DSUM_W-1:0]  best_d_ff, best_d_in;
   logic [IDENT_W-1:0] best_id_ff, best_id_in;
   logic               hit;

   assign seat_x  = in_entry[COORD_BITS-1:0];
   assign seat_y  = in_entry[2*COORD_BITS-1:COORD_BITS];
   assign seat_w  = in_entry[3*COORD_BITS-1:2*COORD_BITS];
   assign seat_h  = in_entry[4*COORD_BITS-1:3*COORD_BITS];
   assign seat_id = in_entry[4*COORD_BITS+IDENT_W-1:4*COORD_BITS];

   // doubled-unit centres
   assign seat_cx = CEN_W'({seat_x, 1'b0}) + CEN_W'(seat_w);
   assign seat_cy = CEN_W'({seat_y, 1'b0}) + CEN_W'(seat_h);

   always_comb begin
      dx_in     = (face_cx >= seat_cx) ? (face_cx - seat_cx) : (seat_cx - face_cx);
      dy_in     = (face_cy >= seat_cy) ? (face_cy - seat_cy) : (seat_cy - face_cy);
      w3_in     = CEN_W'({seat_w, 1'b0}) + CEN_W'(seat_w);
      dxsq_in   = SQ_W'(dx_ff) * SQ_W'(dx_ff);
      dysq_in   = SQ_W'(dy_ff) * SQ_W'(dy_ff);
      gate_b_in = SQ_W'(w3_ff) * SQ_W'(w3_ff);
      dsum_in   = DSUM_W'(dxsq_ff) + DSUM_W'(dysq_ff);
   end

   // earlier entry wins ties: replace only on strictly smaller distance
   assign hit = vc_ff && (dsum_ff < DSUM_W'(gate_c_ff)) && (!found_ff || (dsum_ff < best_d_ff));

   always_comb begin
      found_in   = found_ff;
      best_d_in  = best_d_ff;
      best_id_in = best_id_ff;
      if (clear) begin
         found_in = 1'b0;
      end else if (hit) begin
         found_in   = 1'b1;
         best_d_in  = dsum_ff;
         best_id_in = id_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff    <= 1'b0;
         vb_ff    <= 1'b0;
         vc_ff    <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         va_ff    <= in_valid;
         vb_ff    <= va_ff;
         vc_ff    <= vb_ff;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      w3_ff      <= w3_in;
      id_a_ff    <= seat_id;
      dxsq_ff    <= dxsq_in;
      dysq_ff    <= dysq_in;
      gate_b_ff  <= gate_b_in;
      id_b_ff    <= id_a_ff;
      dsum_ff    <= dsum_in;
      gate_c_ff  <= gate_b_ff;
      id_c_ff    <= id_b_ff;
      best_d_ff  <= best_d_in;
      best_id_ff <= best_id_in;
   end

   assign status.busy  = in_valid | va_ff | vb_ff | vc_ff;
   assign status.found = found_ff;
   assign best_dist    = best_d_ff;
   assign best_ident   = best_id_ff;

endmodule

// ===== rtl/gated_nearest_seat_match_core.sv =====
// gated nearest seat match
// req channel carries either a seat write (tuser low) or a face query (tuser high).
// a seat write with seat_index below MAX_SEATS stores one table entry and is done in the cycle of its transfer;
// it gives no result. a query scans entries 0 to seat_count-1 (at most MAX_SEATS)
// and returns one rsp transfer: the nearest seat whose centre lies strictly within
// 1.5 seat widths of the face centre, earlier entry winning ties.
// a query reads one table entry per cycle from the single read port of the seat memory,
// then lets the read register and the three-stage distance pipeline drain, loads the
// result register and returns to idle.
// req_tready is low while a query is scanning; the next request is taken as soon
// as the result is loaded, even while it still waits in the rsp register.
// if the receiver stalls rsp_tready, a following query completes its scan and then
// holds until the earlier result has been taken.
// csr_we writes seat_count; the user must write it only while the block is idle (not enforced by the block).
// reset clears seat_count, the sequencer and rsp_tvalid; table contents are
// undefined until written.
module gated_nearest_seat_match_core #(
   parameter int MAX_SEATS  = gnsm_pkg::MAX_SEATS_DEFAULT,
   parameter int COORD_BITS = gnsm_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // seat_index, seat_x, seat_y, seat_w, seat_h, seat_ident,
   // face_x, face_y, face_w, face_h, zero pad
   input  logic [gnsm_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // action
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // match_ident, match_dist_sq, zero pad
   output logic [gnsm_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // matched
   output logic                                rsp_tuser,
   input  logic                                csr_we,
   input  logic [gnsm_pkg::COUNT_W-1:0]        csr_wdata
);

   import gnsm_pkg::*;

   localparam int AW      = (MAX_SEATS > 1) ? $clog2(MAX_SEATS) : 1;
   localparam int CW      = $clog2(MAX_SEATS + 1);
   localparam int WIDE    = (CW > COUNT_W) ? CW : COUNT_W;
   localparam int ENTRY_W = 4 * COORD_BITS + IDENT_W;
   localparam int CEN_W   = COORD_BITS + 2;
   localparam int DSUM_W  = 2 * CEN_W + 1;
   localparam int SAT_W   = (DSUM_W > DIST_W) ? DSUM_W : DIST_W;

   gnsm_state_type       state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [CW-1:0]        n_ff, n_in;
   logic [CW-1:0]        issue_ff, issue_in;
   logic [CEN_W-1:0]     fcx_ff, fcx_in;
   logic [CEN_W-1:0]     fcy_ff, fcy_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_matched_ff, rsp_matched_in;
   logic [IDENT_W-1:0]   rsp_ident_ff, rsp_ident_in;
   logic [DIST_W-1:0]    rsp_dist_ff, rsp_dist_in;

   logic                  req_accept;
   logic                  wr_en;
   logic [ENTRY_W-1:0]    wr_data;
   logic                  rd_en;
   logic                  rd_valid;
   logic [ENTRY_W-1:0]    rd_data;
   logic                  scan_clear;
   logic                  rsp_load;
   logic [CW-1:0]         count_clamped;
   logic [COORD_BITS-1:0] face_x, face_y, face_w, face_h;
   logic [CEN_W-1:0]      face_cx, face_cy;
   gnsm_scan_status_type  status;
   logic [DSUM_W-1:0]     best_dist;
   logic [IDENT_W-1:0]    best_ident;
   logic [SAT_W-1:0]      best_dist_ext;
   logic [DIST_W-1:0]     best_dist_sat;

   assign req_accept = req_tvalid & req_tready;

   assign wr_en = req_accept && (req_tuser == ACTION_WRITE) &&
                  (WIDE'(req_tdata[SEAT_X_LSB-1:SEAT_INDEX_LSB]) < WIDE'(MAX_SEATS));

   assign wr_data = {req_tdata[SEAT_IDENT_LSB+IDENT_W-1:SEAT_IDENT_LSB],
                     COORD_BITS'(req_tdata[SEAT_IDENT_LSB-1:SEAT_H_LSB]),
                     COORD_BITS'(req_tdata[SEAT_H_LSB-1:SEAT_W_LSB]),
                     COORD_BITS'(req_tdata[SEAT_W_LSB-1:SEAT_Y_LSB]),
                     COORD_BITS'(req_tdata[SEAT_Y_LSB-1:SEAT_X_LSB])};

   assign face_x = COORD_BITS'(req_tdata[FACE_Y_LSB-1:FACE_X_LSB]);
   assign face_y = COORD_BITS'(req_tdata[FACE_W_LSB-1:FACE_Y_LSB]);
   assign face_w = COORD_BITS'(req_tdata[FACE_H_LSB-1:FACE_W_LSB]);
   assign face_h = COORD_BITS'(req_tdata[REQ_FIELDS_W-1:FACE_H_LSB]);

   assign face_cx = CEN_W'({face_x, 1'b0}) + CEN_W'(face_w);
   assign face_cy = CEN_W'({face_y, 1'b0}) + CEN_W'(face_h);

   assign count_clamped = (WIDE'(count_ff) > WIDE'(MAX_SEATS)) ? CW'(MAX_SEATS)
                                                               : CW'(count_ff);

   assign count_in = csr_we ? csr_wdata : count_ff;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      rd_en      = 1'b0;
      issue_in   = issue_ff;
      n_in       = n_ff;
      fcx_in     = fcx_ff;
      fcy_in     = fcy_ff;
      scan_clear = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && (req_tuser == ACTION_QUERY)) begin
               n_in       = count_clamped;
               issue_in   = '0;
               fcx_in     = face_cx;
               fcy_in     = face_cy;
               scan_clear = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue_ff < n_ff) begin
               rd_en    = 1'b1;
               issue_in = issue_ff + 1'b1;
            end else if (!status.busy) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // report saturates, gating above used the full value
   assign best_dist_ext = SAT_W'(best_dist);
   assign best_dist_sat = (best_dist_ext > SAT_W'(DIST_MAX)) ? DIST_MAX
                                                             : DIST_W'(best_dist_ext);

   always_comb begin
      rsp_matched_in = rsp_matched_ff;
      rsp_ident_in   = rsp_ident_ff;
      rsp_dist_in    = rsp_dist_ff;
      if (rsp_load) begin
         rsp_matched_in = status.found;
         rsp_ident_in   = status.found ? best_ident : '0;
         rsp_dist_in    = status.found ? best_dist_sat : '0;
      end
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         issue_ff     <= '0;
         n_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         issue_ff     <= issue_in;
         n_ff         <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      fcx_ff         <= fcx_in;
      fcy_ff         <= fcy_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_ident_ff   <= rsp_ident_in;
      rsp_dist_ff    <= rsp_dist_in;
   end

   gnsm_seat_table #(
      .DEPTH   (MAX_SEATS),
      .ENTRY_W (ENTRY_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (AW'(req_tdata[SEAT_X_LSB-1:SEAT_INDEX_LSB])),
      .wr_data  (wr_data),
      .rd_en    (rd_en),
      .rd_addr  (issue_ff[AW-1:0]),
      .rd_valid (rd_valid),
      .rd_data  (rd_data)
   );

   gnsm_dist_unit #(
      .COORD_BITS (COORD_BITS)
   ) u_dist (
      .clock      (clock),
      .reset      (reset),
      .clear      (scan_clear),
      .in_valid   (rd_valid),
      .in_entry   (rd_data),
      .face_cx    (fcx_ff),
      .face_cy    (fcy_ff),
      .status     (status),
      .best_dist  (best_dist),
      .best_ident (best_ident)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_matched_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_FIELDS_W){1'b0}}, rsp_dist_ff, rsp_ident_ff};

endmodule
